/* rtl/mspc_pkg.sv */
`default_nettype none
package mspc_pkg;

   localparam int SENSOR_COUNT = 2;
   localparam int SIDX_W      = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
   localparam int ACC_W       = 38;
   localparam int RAD_W       = 35;
   localparam int ROOT_W      = 26;
   localparam int DVD_W       = 39;
   localparam int QUO_W       = 17;
   localparam logic [14:0] DIST_RESET = 15'd100;
   localparam logic signed [15:0] Q_ONE = 16'sh7fff;

   typedef struct packed {
      logic en;
      logic clr;
      logic neg;
   } mac_op_type;

   function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
      logic signed [15:0] r;
      if (v > 24'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -24'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // sign of term j in hamilton product component c
   function automatic logic qmul_neg(input logic [1:0] c, input logic [1:0] j);
      logic n;
      case (c)
         2'd0: n = (j != 2'd0);
         2'd1: n = (j == 2'd3);
         2'd2: n = (j == 2'd1);
         2'd3: n = (j == 2'd2);
         default: n = 1'b0;
      endcase
      return n;
   endfunction

endpackage
`default_nettype wire

/* rtl/mspc_mac.sv */
`default_nettype none
module mspc_mac (
   input  wire logic                              clock,
   input  wire mspc_pkg::mac_op_type              op,
   input  wire logic signed [17:0]                a,
   input  wire logic signed [17:0]                b,
   output logic signed [mspc_pkg::ACC_W-1:0]      acc
);
   import mspc_pkg::*;

   logic signed [35:0]      prod;
   logic signed [ACC_W-1:0] term;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;

   always_comb begin
      prod = a * b;
      term = op.neg ? -ACC_W'(prod) : ACC_W'(prod);
      acc_in = op.clr ? term : acc_ff + term;
   end

   always_ff @(posedge clock) begin
      if (op.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;
endmodule
`default_nettype wire

/* rtl/mspc_sqrt.sv */
`default_nettype none
module mspc_sqrt (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [mspc_pkg::RAD_W-1:0]      radicand,
   output logic                                 done,
   output logic [mspc_pkg::ROOT_W-1:0]          root
);
   import mspc_pkg::*;

   logic [51:0]       v_ff, v_in;
   logic [27:0]       rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [29:0]       rem_n;
   logic [29:0]       trial;
   logic              ge;

   // two radicand bits per step, radicand shifted up by 16
   always_comb begin
      rem_n = {rem_ff, v_ff[51:50]};
      trial = {2'b00, root_ff, 2'b01};
      ge = (rem_n >= trial);
      v_in = v_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         v_in = {1'b0, radicand, 16'b0};
         rem_in = '0;
         root_in = '0;
         cnt_in = 5'(ROOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         v_in = {v_ff[49:0], 2'b00};
         rem_in = ge ? 28'(rem_n - trial) : 28'(rem_n);
         root_in = {root_ff[ROOT_W-2:0], ge};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      v_ff <= v_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

/* rtl/mspc_div.sv */
`default_nettype none
module mspc_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [mspc_pkg::DVD_W-1:0]      dividend,
   input  wire logic [mspc_pkg::ROOT_W-1:0]     divisor,
   output logic                                 done,
   output logic [mspc_pkg::QUO_W-1:0]           quotient
);
   import mspc_pkg::*;

   logic [ROOT_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0]  num_ff, num_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ROOT_W:0]   rem_n;
   logic              ge;

   // quotient is known to fit QUO_W bits, so upper dividend bits seed the remainder
   always_comb begin
      rem_n = {rem_ff, num_ff[QUO_W-1]};
      ge = (rem_n >= {1'b0, divisor});
      rem_in = rem_ff;
      num_in = num_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = ROOT_W'(dividend[DVD_W-1:QUO_W]);
         num_in = dividend[QUO_W-1:0];
         quo_in = '0;
         cnt_in = 5'(QUO_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? ROOT_W'(rem_n - {1'b0, divisor}) : ROOT_W'(rem_n);
         num_in = {num_ff[QUO_W-2:0], 1'b0};
         quo_in = {quo_ff[QUO_W-2:0], ge};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

/* rtl/motion_sensor_pose_calibrator.sv */
// timing from req beat to rsp_valid is set by the 26-step square root, four 17-step divisions
//   and the steps through the one shared multiply-accumulate unit, fewer when docked or
//   uncalibrated; a zero quaternion skips the square root and the divisions
// records: one at a time, the next accepted once the last leaves ST_DONE, later while rsp stalls;
//   a finished result waits in the output register while the next record is accepted
// reset: synchronous, clears calibration, mirror, sign and previous positions, identity inverses
`default_nettype none
module motion_sensor_pose_calibrator (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [14:0]        csr_dock_distance_mm,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_sensor_id,
   input  wire logic signed [15:0] req_raw_pos_x,
   input  wire logic signed [15:0] req_raw_pos_y,
   input  wire logic signed [15:0] req_raw_pos_z,
   input  wire logic signed [15:0] req_raw_quat_w,
   input  wire logic signed [15:0] req_raw_quat_x,
   input  wire logic signed [15:0] req_raw_quat_y,
   input  wire logic signed [15:0] req_raw_quat_z,
   input  wire logic [7:0]         req_button_byte,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_out_sensor,
   output logic signed [15:0]      rsp_pos_x,
   output logic signed [15:0]      rsp_pos_y,
   output logic signed [15:0]      rsp_pos_z,
   output logic signed [15:0]      rsp_quat_w,
   output logic signed [15:0]      rsp_quat_x,
   output logic signed [15:0]      rsp_quat_y,
   output logic signed [15:0]      rsp_quat_z,
   output logic                    rsp_docked,
   output logic                    rsp_calibrated,
   output logic [6:0]              rsp_button_bits
);
   import mspc_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001,
      ST_SQ   = 10'b0000000010,
      ST_DSQ  = 10'b0000000100,
      ST_SQRT = 10'b0000001000,
      ST_DIV  = 10'b0000010000,
      ST_UPD  = 10'b0000100000,
      ST_QMUL = 10'b0001000000,
      ST_POS  = 10'b0010000000,
      ST_DOT  = 10'b0100000000,
      ST_DONE = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [4:0]  k_ff, k_in;
   logic        wait_ff, wait_in;
   logic        rsp_valid_ff;
   logic [14:0] dist_ff;

   logic              sid_ff;
   logic [SIDX_W-1:0] s_ff;
   logic signed [16:0] q_ff [4];
   logic signed [15:0] p_ff [3];
   logic [7:0]         btn_ff;
   logic [RAD_W-1:0]   sum_ff;
   logic               dock_ff;
   logic signed [15:0] nq_ff [4];
   logic signed [15:0] rq_ff [4];
   logic signed [16:0] pt_ff [3];

   logic               calv_ff [SENSOR_COUNT];
   logic               mir_ff  [SENSOR_COUNT];
   logic               xs_ff   [SENSOR_COUNT];
   logic signed [15:0] prev_ff [SENSOR_COUNT][3];
   logic signed [15:0] inv_ff  [SENSOR_COUNT][4];

   logic               out_sensor_ff;
   logic signed [15:0] out_pos_ff [3];
   logic signed [15:0] out_quat_ff [4];
   logic               out_docked_ff;
   logic               out_cal_ff;
   logic [6:0]         out_btn_ff;

   mac_op_type                mac_op;
   logic signed [17:0]        mac_a, mac_b;
   logic signed [ACC_W-1:0]   acc;
   logic                      sq_start, sq_done;
   logic [ROOT_W-1:0]         sq_root;
   logic                      dv_start, dv_done;
   logic [DVD_W-1:0]          dv_dividend;
   logic [QUO_W-1:0]          dv_quo;
   logic signed [16:0]        q_cur;
   logic [15:0]               mag;
   logic [SIDX_W-1:0]         s_req;
   logic                      out_load;
   logic                      dock_mir;
   logic signed [16:0]        tx;
   logic signed [16:0]        px;
   logic signed [23:0]        rnd;

   mspc_mac u_mac (
      .clock (clock),
      .op    (mac_op),
      .a     (mac_a),
      .b     (mac_b),
      .acc   (acc)
   );

   mspc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sum_ff),
      .done     (sq_done),
      .root     (sq_root)
   );

   mspc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dv_start),
      .dividend (dv_dividend),
      .divisor  (sq_root),
      .done     (dv_done),
      .quotient (dv_quo)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      s_req = (32'(req_sensor_id) < SENSOR_COUNT) ? SIDX_W'(req_sensor_id)
                                                  : SIDX_W'(SENSOR_COUNT - 1);
      q_cur = q_ff[k_ff[1:0]];
      mag = q_cur[16] ? 16'(-q_cur) : q_cur[15:0];
      dv_dividend = DVD_W'({mag, 23'b0}) + DVD_W'(sq_root >> 1);
      dock_mir = (p_ff[1] > 16'sd0) || (p_ff[2] > 16'sd0);
      tx = dock_mir ? -17'(p_ff[0]) : 17'(p_ff[0]);
      px = xs_ff[s_ff] ? -17'(p_ff[0]) : 17'(p_ff[0]);
      rnd = 24'((acc + ACC_W'(16384)) >>> 15);
   end

   // operand select for the shared multiply-accumulate
   always_comb begin
      mac_op = '0;
      mac_a = '0;
      mac_b = '0;
      case (state_ff)
         ST_SQ: begin
            mac_op.en = 1'b1;
            mac_op.clr = (k_ff == 5'd0);
            mac_a = 18'(q_cur);
            mac_b = 18'(q_cur);
         end
         ST_DSQ: begin
            mac_op.clr = (k_ff == 5'd0);
            case (k_ff)
               5'd0, 5'd1, 5'd2: begin
                  mac_op.en = 1'b1;
                  mac_a = 18'(p_ff[k_ff[1:0]]);
                  mac_b = 18'(p_ff[k_ff[1:0]]);
               end
               5'd3: begin
                  // subtract radius squared, sign gives the docking test
                  mac_op.en = 1'b1;
                  mac_op.neg = 1'b1;
                  mac_a = $signed({3'b000, dist_ff});
                  mac_b = $signed({3'b000, dist_ff});
               end
               default: mac_op.en = 1'b0;
            endcase
         end
         ST_QMUL: begin
            if (!k_ff[4]) begin
               mac_op.en = 1'b1;
               mac_op.clr = (k_ff[1:0] == 2'd0);
               mac_op.neg = qmul_neg(k_ff[3:2], k_ff[1:0]);
               mac_a = 18'(nq_ff[k_ff[1:0]]);
               mac_b = 18'(inv_ff[s_ff][k_ff[1:0] ^ k_ff[3:2]]);
            end
         end
         ST_DOT: begin
            if (k_ff < 5'd3) begin
               mac_op.en = 1'b1;
               mac_op.clr = (k_ff == 5'd0);
               mac_a = 18'(pt_ff[k_ff[1:0]]);
               mac_b = 18'(prev_ff[s_ff][k_ff[1:0]]);
            end
         end
         default: mac_op = '0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      k_in = k_ff;
      wait_in = wait_ff;
      sq_start = 1'b0;
      dv_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SQ;
               k_in = '0;
            end
         end
         ST_SQ: begin
            k_in = k_ff + 5'd1;
            if (k_ff == 5'd3) begin
               state_in = ST_DSQ;
               k_in = '0;
            end
         end
         ST_DSQ: begin
            k_in = k_ff + 5'd1;
            if (k_ff == 5'd4) begin
               k_in = '0;
               wait_in = 1'b0;
               state_in = (sum_ff == '0) ? ST_UPD : ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (!wait_ff) begin
               sq_start = 1'b1;
               wait_in = 1'b1;
            end else if (sq_done) begin
               wait_in = 1'b0;
               k_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!wait_ff) begin
               dv_start = 1'b1;
               wait_in = 1'b1;
            end else if (dv_done) begin
               wait_in = 1'b0;
               k_in = k_ff + 5'd1;
               if (k_ff == 5'd3) begin
                  state_in = ST_UPD;
               end
            end
         end
         ST_UPD: begin
            k_in = '0;
            state_in = (calv_ff[s_ff] || dock_ff) ? ST_QMUL : ST_POS;
         end
         ST_QMUL: begin
            k_in = k_ff + 5'd1;
            if (k_ff == 5'd16) begin
               state_in = ST_POS;
            end
         end
         ST_POS: begin
            k_in = '0;
            state_in = (calv_ff[s_ff] && !dock_ff) ? ST_DOT : ST_DONE;
         end
         ST_DOT: begin
            k_in = k_ff + 5'd1;
            if (k_ff == 5'd3) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff <= '0;
         wait_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff <= k_in;
         wait_ff <= wait_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff <= DIST_RESET;
      end else if (csr_valid) begin
         dist_ff <= csr_dock_distance_mm;
      end
   end

   // record capture and working values
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         sid_ff <= req_sensor_id;
         s_ff <= s_req;
         p_ff[0] <= req_raw_pos_x;
         p_ff[1] <= req_raw_pos_y;
         p_ff[2] <= req_raw_pos_z;
         q_ff[0] <= 17'(req_raw_quat_w);
         q_ff[1] <= 17'(req_raw_quat_x);
         q_ff[2] <= -17'(req_raw_quat_y);
         q_ff[3] <= -17'(req_raw_quat_z);
         btn_ff <= req_button_byte;
      end
      if (state_ff == ST_DSQ && k_ff == 5'd0) begin
         sum_ff <= acc[RAD_W-1:0];
      end
      if (state_ff == ST_DSQ && k_ff == 5'd4) begin
         dock_ff <= acc[ACC_W-1];
         if (sum_ff == '0) begin
            nq_ff[0] <= Q_ONE;
            nq_ff[1] <= '0;
            nq_ff[2] <= '0;
            nq_ff[3] <= '0;
         end
      end
      if (state_ff == ST_DIV && wait_ff && dv_done) begin
         nq_ff[k_ff[1:0]] <= q_cur[16] ? sat16(-24'(dv_quo)) : sat16(24'(dv_quo));
      end
      if (state_ff == ST_QMUL && k_ff != 5'd0 && k_ff[1:0] == 2'd0) begin
         rq_ff[k_ff[3:2] - 2'd1] <= sat16(rnd);
      end
      if (state_ff == ST_POS) begin
         if (calv_ff[s_ff]) begin
            pt_ff[0] <= mir_ff[s_ff] ? -px : px;
            pt_ff[1] <= mir_ff[s_ff] ? -17'(p_ff[1]) : 17'(p_ff[1]);
            pt_ff[2] <= mir_ff[s_ff] ? -17'(p_ff[2]) : 17'(p_ff[2]);
         end else begin
            pt_ff[0] <= 17'(p_ff[0]);
            pt_ff[1] <= 17'(p_ff[1]);
            pt_ff[2] <= 17'(p_ff[2]);
         end
      end
      if (state_ff == ST_DOT && k_ff == 5'd3 && acc[ACC_W-1]) begin
         pt_ff[0] <= -pt_ff[0];
         pt_ff[1] <= -pt_ff[1];
         pt_ff[2] <= -pt_ff[2];
      end
   end

   // per-sensor calibration state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            calv_ff[i] <= 1'b0;
            mir_ff[i] <= 1'b0;
            xs_ff[i] <= 1'b0;
            prev_ff[i][0] <= '0;
            prev_ff[i][1] <= '0;
            prev_ff[i][2] <= '0;
            inv_ff[i][0] <= Q_ONE;
            inv_ff[i][1] <= '0;
            inv_ff[i][2] <= '0;
            inv_ff[i][3] <= '0;
         end
      end else begin
         if (state_ff == ST_UPD && dock_ff) begin
            calv_ff[s_ff] <= 1'b1;
            inv_ff[s_ff][0] <= nq_ff[0];
            inv_ff[s_ff][1] <= sat16(-24'(nq_ff[1]));
            inv_ff[s_ff][2] <= sat16(-24'(nq_ff[2]));
            inv_ff[s_ff][3] <= sat16(-24'(nq_ff[3]));
            mir_ff[s_ff] <= dock_mir;
            if (s_ff == '0) begin
               xs_ff[s_ff] <= !(tx < 17'sd0);
            end else begin
               xs_ff[s_ff] <= !(tx > 17'sd0);
            end
         end
         if (state_ff == ST_DOT && k_ff == 5'd3 && acc[ACC_W-1]) begin
            mir_ff[s_ff] <= !mir_ff[s_ff];
         end
         if (out_load) begin
            prev_ff[s_ff][0] <= sat16(24'(pt_ff[0]));
            prev_ff[s_ff][1] <= sat16(24'(pt_ff[1]));
            prev_ff[s_ff][2] <= sat16(24'(pt_ff[2]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_sensor_ff <= sid_ff;
         out_pos_ff[0] <= sat16(24'(pt_ff[0]));
         out_pos_ff[1] <= sat16(24'(pt_ff[1]));
         out_pos_ff[2] <= sat16(24'(pt_ff[2]));
         for (int i = 0; i < 4; i++) begin
            out_quat_ff[i] <= calv_ff[s_ff] ? rq_ff[i] : nq_ff[i];
         end
         out_docked_ff <= dock_ff;
         out_cal_ff <= calv_ff[s_ff];
         out_btn_ff <= {btn_ff[6], btn_ff[0], btn_ff[4], btn_ff[1],
                        btn_ff[3], btn_ff[2], btn_ff[5]};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_sensor = out_sensor_ff;
   assign rsp_pos_x = out_pos_ff[0];
   assign rsp_pos_y = out_pos_ff[1];
   assign rsp_pos_z = out_pos_ff[2];
   assign rsp_quat_w = out_quat_ff[0];
   assign rsp_quat_x = out_quat_ff[1];
   assign rsp_quat_y = out_quat_ff[2];
   assign rsp_quat_z = out_quat_ff[3];
   assign rsp_docked = out_docked_ff;
   assign rsp_calibrated = out_cal_ff;
   assign rsp_button_bits = out_btn_ff;
endmodule
`default_nettype wire
